### rtl/core/xcfr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the XOR-checked frame receiver.
// No dependencies; used by xcfr_parser and xor_checked_frame_receiver.
package xcfr_pkg;

  // Frame layout
  localparam int unsigned FrameLen = 11;
  localparam int unsigned PosW     = 4;
  localparam int unsigned PayloadN = 8;
  localparam int unsigned PayIdxW  = 3;

  localparam logic [PosW-1:0] PosIdle  = 4'd0;
  localparam logic [PosW-1:0] PosCheck = 4'd9;
  localparam logic [PosW-1:0] PosLast  = 4'd10;

  // Configuration registers
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegHeader = 4'd0;
  localparam logic [CfgIdxW-1:0] RegTail   = 4'd1;

  localparam logic [7:0] HeaderReset = 8'd123;
  localparam logic [7:0] TailReset   = 8'd125;

  // One decoded frame
  typedef struct packed {
    logic        [7:0]  flag;
    logic        [7:0]  status;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
  } result_t;

  // Parser status toward the top level
  typedef struct packed {
    logic at_last;   // next beat closes a frame
    logic res_valid; // current beat completes a good frame
  } parse_stat_t;

endpackage

### rtl/core/xcfr_parser.sv
`timescale 1ns / 1ps
// Frame parser: byte position, running XOR, payload and check bytes.
// Depends on xcfr_pkg.
module xcfr_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     beat,
  input  logic [7:0]               rx_byte,
  input  logic [7:0]               header_byte,
  input  logic [7:0]               tail_byte,
  output xcfr_pkg::parse_stat_t    stat,
  output xcfr_pkg::result_t        result
);

  logic [xcfr_pkg::PosW-1:0]    pos_r, pos_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [7:0]                   check_r, check_nxt;
  logic [7:0]                   payload_r [xcfr_pkg::PayloadN];
  logic [xcfr_pkg::PayIdxW-1:0] wr_idx;
  logic                         payload_we;
  logic                         good_frame;

  // positions 1..8 map to payload slots 0..7
  assign wr_idx = pos_r[xcfr_pkg::PayIdxW-1:0] - 3'd1;
  assign payload_we = beat && (pos_r != xcfr_pkg::PosIdle) && (pos_r < xcfr_pkg::PosCheck);
  assign good_frame = (rx_byte == tail_byte) && (xor_r == check_r);

  // Per-beat frame state update
  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    check_nxt = check_r;
    stat.res_valid = 1'b0;
    stat.at_last   = (pos_r >= xcfr_pkg::PosLast);
    if (beat) begin
      if (pos_r == xcfr_pkg::PosIdle) begin
        if (rx_byte == header_byte) begin
          xor_nxt = rx_byte;
          pos_nxt = 4'd1;
        end
      end else if (pos_r < xcfr_pkg::PosCheck) begin
        xor_nxt = xor_r ^ rx_byte;
        pos_nxt = pos_r + 4'd1;
      end else if (pos_r == xcfr_pkg::PosCheck) begin
        check_nxt = rx_byte;
        pos_nxt   = pos_r + 4'd1;
      end else begin
        // last position (anything past it counts as last too)
        pos_nxt        = xcfr_pkg::PosIdle;
        stat.res_valid = good_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= xcfr_pkg::PosIdle;
      xor_r   <= 8'd0;
      check_r <= 8'd0;
    end else begin
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
      check_r <= check_nxt;
    end
  end

  // Payload bytes 1..8, no reset
  always_ff @(posedge clk) begin
    if (payload_we) begin
      payload_r[wr_idx] <= rx_byte;
    end
  end

  // Big-endian field assembly
  assign result.flag   = payload_r[0];
  assign result.status = payload_r[1];
  assign result.vel_x  = {payload_r[2], payload_r[3]};
  assign result.vel_y  = {payload_r[4], payload_r[5]};
  assign result.vel_z  = {payload_r[6], payload_r[7]};

endmodule

### rtl/core/xor_checked_frame_receiver.sv
`timescale 1ns / 1ps
// Top level of the XOR-checked frame receiver: config registers, output register.
// Depends on xcfr_pkg and xcfr_parser.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_rx_byte
//  out_    | output    | out_valid/out_stall | out_flag, out_status, out_vel_x/y/z
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte beat per cycle unless in_stall holds it; a good frame's result appears on out_
// in the cycle after its tail beat. Synchronous active-low reset returns to waiting for a
// header and restores header 123 and tail 125. in_stall rises only when a held
// result is stalled and the next beat would close a frame; cfg_ready is always high.
module xor_checked_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_flag,
  output logic [7:0]                    out_status,
  output logic signed [15:0]            out_vel_x,
  output logic signed [15:0]            out_vel_y,
  output logic signed [15:0]            out_vel_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xcfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic [7:0]            header_r;
  logic [7:0]            tail_r;
  logic                  out_valid_r, out_valid_nxt;
  xcfr_pkg::result_t     out_r;
  xcfr_pkg::result_t     result;
  xcfr_pkg::parse_stat_t stat;
  logic                  beat;

  assign cfg_ready = 1'b1;

  // Hold input only when a frame could close into a blocked output
  assign in_stall = out_valid_r && out_stall && stat.at_last;
  assign beat     = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= xcfr_pkg::HeaderReset;
      tail_r   <= xcfr_pkg::TailReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xcfr_pkg::RegHeader: header_r <= cfg_data;
        xcfr_pkg::RegTail:   tail_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  xcfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (beat),
    .rx_byte     (in_rx_byte),
    .header_byte (header_r),
    .tail_byte   (tail_r),
    .stat        (stat),
    .result      (result)
  );

  // Output register
  assign out_valid_nxt = stat.res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid) begin
      out_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_flag   = out_r.flag;
  assign out_status = out_r.status;
  assign out_vel_x  = out_r.vel_x;
  assign out_vel_y  = out_r.vel_y;
  assign out_vel_z  = out_r.vel_z;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for xor_checked_frame_receiver: directed and random byte streams,
// checked against a frame decoder kept inside the bench. Needs xcfr_pkg and the RTL.
module tb;

  localparam logic [xcfr_pkg::CfgIdxW-1:0] RegUnmapped = 4'd15;
  localparam int HoldCycles  = 300;
  localparam int IdlePct     = 17;
  localparam int RandItems   = 320;
  localparam int PhaseItems  = 64;
  localparam int DrainCycles = 4;
  localparam int ShownMax    = 10;

  localparam logic [7:0] HdrSet  [3] = '{8'h00, 8'hFF, 8'h5A};
  localparam logic [7:0] TailSet [3] = '{8'hFF, 8'h00, 8'h5A};

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_valid   = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_rx_byte = '0;
  logic                         out_valid;
  logic                         out_stall  = 1'b0;
  logic [7:0]                   out_flag;
  logic [7:0]                   out_status;
  logic signed [15:0]           out_vel_x;
  logic signed [15:0]           out_vel_y;
  logic signed [15:0]           out_vel_z;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [xcfr_pkg::CfgIdxW-1:0] cfg_index  = '0;
  logic [7:0]                   cfg_data   = '0;

  xor_checked_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_flag   (out_flag),
    .out_status (out_status),
    .out_vel_x  (out_vel_x),
    .out_vel_y  (out_vel_y),
    .out_vel_z  (out_vel_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Bench copy of the receiver state and registers
  logic [7:0]                hdr_cfg    = xcfr_pkg::HeaderReset;
  logic [7:0]                tail_cfg   = xcfr_pkg::TailReset;
  logic [xcfr_pkg::PosW-1:0] frame_pos  = xcfr_pkg::PosIdle;
  logic [7:0]                xor_acc    = '0;
  logic [7:0]                check_byte = '0;
  logic [7:0]                payload [xcfr_pkg::PayloadN];

  xcfr_pkg::result_t frames_due [$];
  logic [7:0]        rx_bytes_pending [$];
  int                mismatches     = 0;
  bit                no_idle        = 1'b0;
  logic              hold_start     = 1'b0;
  int                hold_left      = 0;

  // Advance the frame decoder by one accepted byte
  function automatic void decode_byte(input logic [7:0] b);
    xcfr_pkg::result_t            r;
    logic [xcfr_pkg::PayIdxW-1:0] slot;
    slot = frame_pos[xcfr_pkg::PayIdxW-1:0] - 3'd1;
    if (frame_pos == xcfr_pkg::PosIdle) begin
      if (b == hdr_cfg) begin
        xor_acc   = b;
        frame_pos = xcfr_pkg::PosIdle + 1'b1;
      end
    end else if (frame_pos < xcfr_pkg::PosCheck) begin
      payload[slot] = b;
      xor_acc   = xor_acc ^ b;
      frame_pos = frame_pos + 1'b1;
    end else if (frame_pos == xcfr_pkg::PosCheck) begin
      check_byte = b;
      frame_pos  = frame_pos + 1'b1;
    end else begin
      // closing byte; anything past the check position counts as the tail
      frame_pos = xcfr_pkg::PosIdle;
      if (b == tail_cfg && xor_acc == check_byte) begin
        r.flag   = payload[0];
        r.status = payload[1];
        r.vel_x  = {payload[2], payload[3]};
        r.vel_y  = {payload[4], payload[5]};
        r.vel_z  = {payload[6], payload[7]};
        frames_due.push_back(r);
      end
    end
  endfunction

  // Queue one full frame built with the current header and tail
  function automatic void push_frame(input logic [7:0] flag, input logic [7:0] status,
                                     input logic signed [15:0] vx,
                                     input logic signed [15:0] vy,
                                     input logic signed [15:0] vz,
                                     input bit bad_check, input bit bad_tail);
    logic [7:0] fb [xcfr_pkg::FrameLen];
    logic [7:0] chk;
    fb[0] = hdr_cfg;
    fb[1] = flag;
    fb[2] = status;
    {fb[3], fb[4]} = vx;
    {fb[5], fb[6]} = vy;
    {fb[7], fb[8]} = vz;
    chk = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5] ^ fb[6] ^ fb[7] ^ fb[8];
    fb[xcfr_pkg::PosCheck] = bad_check ? chk ^ 8'($urandom_range(1, 255)) : chk;
    fb[xcfr_pkg::PosLast]  = bad_tail ? tail_cfg ^ 8'($urandom_range(1, 255)) : tail_cfg;
    foreach (fb[i]) rx_bytes_pending.push_back(fb[i]);
  endfunction

  // Payload byte, biased toward extremes and the header value
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return hdr_cfg;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_vel();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly good frames, mixed with corrupted frames, truncated frames and idle-line noise.
  // Returns the number of frame bytes queued; noise is not counted.
  function automatic int push_traffic(input int n);
    int         cnt;
    int         sel;
    int         k;
    logic [7:0] nb;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        push_frame(pick_byte(), pick_byte(), pick_vel(), pick_vel(), pick_vel(), 1'b0, 1'b0);
        cnt += xcfr_pkg::FrameLen;
      end else if (sel < 80) begin
        push_frame(pick_byte(), pick_byte(), pick_vel(), pick_vel(), pick_vel(), 1'b1, 1'b0);
        cnt += xcfr_pkg::FrameLen;
      end else if (sel < 88) begin
        push_frame(pick_byte(), pick_byte(), pick_vel(), pick_vel(), pick_vel(), 1'b0, 1'b1);
        cnt += xcfr_pkg::FrameLen;
      end else if (sel < 94) begin
        // header followed by a short run, cut off by whatever comes next
        k = $urandom_range(1, 9);
        rx_bytes_pending.push_back(hdr_cfg);
        repeat (k) rx_bytes_pending.push_back(8'($urandom));
        cnt += k + 1;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          nb = 8'($urandom);
          if (nb == hdr_cfg) nb = ~nb;
          rx_bytes_pending.push_back(nb);
        end
      end
    end
    return cnt;
  endfunction

  task automatic cfg_write(input logic [xcfr_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == xcfr_pkg::RegHeader) hdr_cfg = val;
    else if (idx == xcfr_pkg::RegTail) tail_cfg = val;
  endtask

  // Wait for every queued byte to go in and every decoded frame to come out
  task automatic wait_drained();
    while (rx_bytes_pending.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // Byte driver: holds a stalled beat, otherwise idles at random
  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_rx_byte);
      if (!(in_valid && in_stall)) begin
        if (rx_bytes_pending.size() != 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin : hold_counter
    if (hold_start) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result monitor: compare each accepted beat with the oldest decoded frame
  always @(posedge clk) begin : frame_monitor
    xcfr_pkg::result_t got;
    xcfr_pkg::result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_flag, out_status, out_vel_x, out_vel_y, out_vel_z};
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMax)
            $display("%0t: unexpected frame flag=%0d status=%0d vel=%0d/%0d/%0d", $time,
                     got.flag, got.status, got.vel_x, got.vel_y, got.vel_z);
        end else begin
          want = frames_due.pop_front();
          if (got.flag !== want.flag || got.status !== want.status ||
              got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
              got.vel_z !== want.vel_z) begin
            mismatches++;
            if (mismatches <= ShownMax)
              $display({"%0t: frame exp flag=%0d status=%0d vel=%0d/%0d/%0d,",
                        " got %0d %0d %0d/%0d/%0d"},
                       $time, want.flag, want.status, want.vel_x, want.vel_y, want.vel_z,
                       got.flag, got.status, got.vel_x, got.vel_y, got.vel_z);
          end
        end
      end
      out_stall <= hold_start || hold_left != 0 ||
                   (!no_idle && $urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin : stimulus
    int items;
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle noise, header value inside a frame with extreme values,
    // then a frame whose tail is wrong
    rx_bytes_pending.push_back(8'h00);
    push_frame(xcfr_pkg::HeaderReset, 8'hFF, 16'sh8000, 16'sh7FFF, -16'sd1, 1'b0, 1'b0);
    push_frame(8'h00, xcfr_pkg::HeaderReset, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1);
    wait_drained();

    // Receiver holds off while the sender keeps going, so the input stalls
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    @(negedge clk);
    no_idle = 1'b1;
    repeat (5)
      push_frame(pick_byte(), pick_byte(), pick_vel(), pick_vel(), pick_vel(), 1'b0, 1'b0);
    wait_drained();
    no_idle = 1'b0;

    // Random phases: reset registers first, then extremes, equal values, random
    items = 0;
    phase = 0;
    while (items < RandItems) begin
      if (phase > 0) begin
        if ((phase - 1) % 4 == 3) begin
          cfg_write(xcfr_pkg::RegHeader, 8'($urandom));
          cfg_write(xcfr_pkg::RegTail, 8'($urandom));
        end else begin
          cfg_write(xcfr_pkg::RegHeader, HdrSet[2'((phase - 1) % 4)]);
          cfg_write(xcfr_pkg::RegTail, TailSet[2'((phase - 1) % 4)]);
        end
        // index past the register list must leave both registers alone
        if (phase == 1) cfg_write(RegUnmapped, 8'hA5);
      end
      @(negedge clk);
      no_idle = (phase == 2);
      items += push_traffic(PhaseItems);
      wait_drained();
      no_idle = 1'b0;
      phase++;
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### xor_checked_frame_receiver.f
rtl/core/xcfr_pkg.sv
rtl/core/xcfr_parser.sv
rtl/core/xor_checked_frame_receiver.sv
verif/tb.sv
